/* design/asfc_pkg.sv */
// Types, constants and helper functions shared by the sample format converter.
package asfc_pkg;

    localparam int ZW = 104;
    localparam int ZF = 68;

    typedef logic [ZW-1:0] t_z;

    localparam t_z Z_ONE = t_z'(1) << ZF;

    typedef enum logic [2:0] {
        FMT_U8  = 3'd0,
        FMT_S8  = 3'd1,
        FMT_U16 = 3'd2,
        FMT_S16 = 3'd3,
        FMT_U32 = 3'd4,
        FMT_S32 = 3'd5,
        FMT_F32 = 3'd6
    } t_fmt;

    typedef enum logic [2:0] {
        MODE_ZERO,
        MODE_PASS,
        MODE_I2I,
        MODE_I2F,
        MODE_F2I
    } t_mode;

    typedef enum logic [1:0] {
        W8,
        W16,
        W32
    } t_wcls;

    localparam logic CFG_SRC = 1'b0;
    localparam logic CFG_DST = 1'b1;

    // sideband that travels with every beat
    typedef struct packed {
        t_mode       mode;
        t_wcls       wcls;
        logic        k53;
        logic        sgn;
        logic        tsig;
        logic        zero_f;
        logic        sat_f;
        logic [31:0] direct;
    } t_sb;

    function automatic t_wcls fmt_wcls(input logic [2:0] f);
        t_wcls w;
        if (f < FMT_U16) begin
            w = W8;
        end else if (f < FMT_U32) begin
            w = W16;
        end else begin
            w = W32;
        end
        return w;
    endfunction

    function automatic logic [5:0] wcls_bits(input t_wcls w);
        logic [5:0] b;
        unique case (w)
            W8:      b = 6'd8;
            W16:     b = 6'd16;
            default: b = 6'd32;
        endcase
        return b;
    endfunction

    function automatic logic [31:0] wcls_mask(input t_wcls w);
        logic [31:0] m;
        unique case (w)
            W8:      m = 32'h0000_00FF;
            W16:     m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] wcls_top(input t_wcls w);
        logic [31:0] m;
        unique case (w)
            W8:      m = 32'h0000_0080;
            W16:     m = 32'h0000_8000;
            default: m = 32'h8000_0000;
        endcase
        return m;
    endfunction

    // index of the highest set bit, 0 for an all-zero word
    function automatic logic [6:0] lead_one(input t_z z);
        logic [6:0] l;
        l = '0;
        for (int i = 0; i < ZW; i++) begin
            if (z[i]) begin
                l = 7'(i);
            end
        end
        return l;
    endfunction

endpackage

/* design/asfc_round.sv */
// Three-stage round-to-nearest-even of a fixed-point word to 24 or 53 significant bits.
module asfc_round
    import asfc_pkg::*;
(
    input  logic       i_clk,
    input  logic [2:0] i_adv,
    input  logic       i_on,
    input  logic       i_k53,
    input  t_z         i_z,
    output t_z         o_z
);

    t_z           r_z1;
    logic [6:0]   r_sp1;
    logic         r_do1;
    t_z           r_keep2;
    t_z           r_inc2;
    t_z           r_z3;

    logic [6:0]   n_lead;
    logic [7:0]   n_sp;
    logic         n_do;
    t_z           n_mask;
    t_z           n_low;
    logic [6:0]   n_spm1;
    logic         n_g;
    logic         n_st;
    logic         n_inc;

    always_comb begin
        n_lead = lead_one(i_z);
        n_sp   = {1'b0, n_lead} + 8'd1 - (i_k53 ? 8'd53 : 8'd24);
        n_do   = i_on && (|i_z) && !n_sp[7] && (n_sp != 8'd0);
    end

    always_comb begin
        n_mask = ~t_z'(0) << r_sp1;
        n_low  = r_z1 & ~n_mask;
        n_spm1 = r_sp1 - 7'd1;
        n_g    = n_low[n_spm1];
        n_st   = |(n_low & ~(~t_z'(0) << n_spm1));
        n_inc  = r_do1 && n_g && (n_st || r_z1[r_sp1]);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_z1  <= i_z;
            r_sp1 <= n_sp[6:0];
            r_do1 <= n_do;
        end
        if (i_adv[1]) begin
            r_keep2 <= r_do1 ? (r_z1 & n_mask) : r_z1;
            r_inc2  <= n_inc ? (t_z'(1) << r_sp1) : '0;
        end
        if (i_adv[2]) begin
            r_z3 <= r_keep2 + r_inc2;
        end
    end

    assign o_z = r_z3;

endmodule

/* design/audio_sample_format_converter.sv */
// Top level of the PCM sample format converter (u8/s8/u16/s16/u32/s32/float).
//
//  channel | signals                                  | dir | notes
//  --------+------------------------------------------+-----+------------------------
//  in      | i_in_valid o_in_ready i_in_sample[31:0]  | in  | one sample per beat
//  out     | o_out_valid i_out_ready o_out_sample     | out | one result per beat
//  cfg     | i_cfg_we i_cfg_index i_cfg_data[2:0]     | in  | 0 source, 1 target fmt
//
// Fourteen-stage pipeline; one beat per cycle while the output is not stalled.
// Depth is set by three rounding units (LZC, mask, add) plus entry, offset, scale, lead and exit stages.
// Each stage advances when empty or when the next one advances, so bubbles fill
// under an output stall. Synchronous active-low reset empties the pipe and
// clears both format registers to u8.
module audio_sample_format_converter
    import asfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_in_sample,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_sample,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_data
);

    localparam int NST = 14;
    localparam int ST_M  = 5;
    localparam int ST_F1 = 12;

    logic [2:0]     r_src;
    logic [2:0]     r_dst;
    logic [NST-1:0] r_vld;
    t_sb            r_sb [NST];
    t_sb            n_sb [NST];
    t_sb            n_sb_in;
    logic [NST-1:0] adv;

    t_z             r_za;
    t_z             r_zb;
    t_z             r_zm;
    t_z             r_zf;
    logic [6:0]     r_lead;
    logic [31:0]    r_out;

    t_z             n_za;
    t_z             n_zb;
    t_z             n_zm;
    t_z             z_r1;
    t_z             z_r2;
    t_z             z_r3;
    logic           m_sgn;
    logic [31:0]    f_res;

    // ---------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= FMT_U8;
            r_dst <= FMT_U8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SRC: r_src <= i_cfg_data;
                CFG_DST: r_dst <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control
    always_comb begin
        adv[NST-1] = !r_vld[NST-1] || i_out_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            adv[i] = !r_vld[i] || adv[i+1];
        end
    end

    assign o_in_ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (adv[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // ---------------- entry stage
    always_comb begin
        t_wcls       wsc;
        t_wcls       wdc;
        logic [31:0] v;
        logic [31:0] vf;
        logic [5:0]  ws;
        logic [5:0]  wd;
        logic [31:0] u;
        logic [7:0]  e;
        logic [23:0] m24;
        logic [7:0]  eeff;
        logic [151:0] t;

        wsc  = fmt_wcls(r_src);
        wdc  = fmt_wcls(r_dst);
        ws   = wcls_bits(wsc);
        wd   = wcls_bits(wdc);
        v    = i_in_sample & wcls_mask(wsc);
        vf   = '0;
        u    = r_src[0] ? (v ^ wcls_top(wsc)) : v;
        e    = i_in_sample[30:23];
        m24  = {(e != 8'd0), i_in_sample[22:0]};
        eeff = (e == 8'd0) ? 8'd1 : e;
        t    = 152'(m24) << eeff;

        n_sb_in        = '0;
        n_sb_in.tsig   = r_dst[0];
        n_za           = '0;

        if (r_src == FMT_F32 && r_dst == FMT_F32) begin
            n_sb_in.mode   = MODE_PASS;
            n_sb_in.direct = i_in_sample;
        end else if (r_src > FMT_F32 || r_dst > FMT_F32) begin
            n_sb_in.mode   = MODE_ZERO;
        end else if (r_src == FMT_F32) begin
            n_sb_in.mode   = MODE_F2I;
            n_sb_in.wcls   = wdc;
            n_sb_in.k53    = (wdc == W32);
            n_sb_in.sgn    = i_in_sample[31];
            n_sb_in.zero_f = (e == 8'hFF && i_in_sample[22:0] != 23'd0)
                          || (i_in_sample[31] && e >= 8'd127);
            n_sb_in.sat_f  = !i_in_sample[31] && e >= 8'd129
                          && !(e == 8'hFF && i_in_sample[22:0] != 23'd0);
            n_za           = {34'd0, t[151:82]};
            n_za[0]        = t[82] | (|t[81:0]);
        end else if (r_dst == FMT_F32) begin
            n_sb_in.mode   = MODE_I2F;
            n_sb_in.wcls   = wsc;
            n_sb_in.k53    = (wsc == W32);
            unique case (wsc)
                W8:      n_za = t_z'({1'b0, u[7:0], u[7:0], u[7:0], 7'd0}
                                     + {24'd0, u[7:0]}) << 38;
                W16:     n_za = t_z'({u[15:0], u[15:0]}) << 37;
                default: n_za = t_z'({u, u}) << 5;
            endcase
        end else begin
            n_sb_in.mode   = MODE_I2I;
            vf = (r_src[0] != r_dst[0]) ? (v ^ wcls_top(wsc)) : v;
            if (ws > wd) begin
                n_sb_in.direct = (vf >> (ws - wd)) & wcls_mask(wdc);
            end else begin
                n_sb_in.direct = (vf << (wd - ws)) & wcls_mask(wdc);
            end
        end
    end

    // x + 1 for float input
    always_comb begin
        if (r_sb[0].mode == MODE_F2I) begin
            n_zb = r_sb[0].sgn ? (Z_ONE - r_za) : (Z_ONE + r_za);
        end else begin
            n_zb = r_za;
        end
    end

    asfc_round u_round1 (
        .i_clk (i_clk),
        .i_adv (adv[4:2]),
        .i_on  (r_sb[1].mode == MODE_I2F || r_sb[1].mode == MODE_F2I),
        .i_k53 (r_sb[1].k53),
        .i_z   (r_zb),
        .o_z   (z_r1)
    );

    // p - 1 for int input, s * (2^w - 1) / 2 for float input
    always_comb begin
        t_z tt;
        tt    = '0;
        m_sgn = r_sb[4].sgn;
        n_zm  = z_r1;
        if (r_sb[4].mode == MODE_I2F) begin
            m_sgn = (z_r1 < Z_ONE);
            n_zm  = m_sgn ? (Z_ONE - z_r1) : (z_r1 - Z_ONE);
        end else if (r_sb[4].mode == MODE_F2I) begin
            unique case (r_sb[4].wcls)
                W8:      tt = (z_r1 << 8) - z_r1;
                W16:     tt = (z_r1 << 16) - z_r1;
                default: tt = (z_r1 << 32) - z_r1;
            endcase
            n_zm = (tt >> 1) | t_z'(tt[0]);
        end
    end

    asfc_round u_round2 (
        .i_clk (i_clk),
        .i_adv (adv[8:6]),
        .i_on  (r_sb[ST_M].mode == MODE_I2F || r_sb[ST_M].mode == MODE_F2I),
        .i_k53 (r_sb[ST_M].k53),
        .i_z   (r_zm),
        .o_z   (z_r2)
    );

    asfc_round u_round3 (
        .i_clk (i_clk),
        .i_adv (adv[11:9]),
        .i_on  (r_sb[8].mode == MODE_I2F),
        .i_k53 (1'b0),
        .i_z   (z_r2),
        .o_z   (z_r3)
    );

    // truncate and saturate for integer targets
    always_comb begin
        logic        over;
        logic [31:0] uu;
        unique case (r_sb[11].wcls)
            W8:      over = |z_r3[ZW-1:ZF+8];
            W16:     over = |z_r3[ZW-1:ZF+16];
            default: over = |z_r3[ZW-1:ZF+32];
        endcase
        if (r_sb[11].zero_f) begin
            uu = '0;
        end else if (r_sb[11].sat_f || over) begin
            uu = wcls_mask(r_sb[11].wcls);
        end else begin
            uu = z_r3[ZF+31:ZF] & wcls_mask(r_sb[11].wcls);
        end
        if (r_sb[11].tsig) begin
            uu = uu ^ wcls_top(r_sb[11].wcls);
        end
        f_res = uu & wcls_mask(r_sb[11].wcls);
    end

    always_comb begin
        n_sb[0] = n_sb_in;
        for (int i = 1; i < NST; i++) begin
            n_sb[i] = r_sb[i-1];
        end
        n_sb[ST_M].sgn = m_sgn;
        if (r_sb[11].mode == MODE_F2I) begin
            n_sb[ST_F1].direct = f_res;
        end
    end

    // float encode
    logic [31:0] n_out;
    always_comb begin
        t_z sh;
        sh = r_zf << (7'd103 - r_lead);
        if (r_sb[ST_F1].mode != MODE_I2F) begin
            n_out = r_sb[ST_F1].direct;
        end else if (r_zf == '0) begin
            n_out = '0;
        end else begin
            n_out = {r_sb[ST_F1].sgn, 8'({1'b0, r_lead}) + 8'd59, sh[102:80]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NST; i++) begin
            if (adv[i]) begin
                r_sb[i] <= n_sb[i];
            end
        end
        if (adv[0]) begin
            r_za <= n_za;
        end
        if (adv[1]) begin
            r_zb <= n_zb;
        end
        if (adv[ST_M]) begin
            r_zm <= n_zm;
        end
        if (adv[ST_F1]) begin
            r_zf   <= z_r3;
            r_lead <= lead_one(z_r3);
        end
        if (adv[NST-1]) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid  = r_vld[NST-1];
    assign o_out_sample = r_out;

    // any bubble in the pipe must let a new beat in
    a_ready_on_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&r_vld) |-> o_in_ready)
        else $error("input stalled with an empty stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[0])
        else $error("accepted beat lost at entry");

    a_i2f_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_sb[NST-1].mode == MODE_I2F |-> o_out_sample[30:23] <= 8'd127)
        else $error("int to float result above magnitude one");

    a_f2i_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_sb[NST-1].mode == MODE_F2I && r_sb[NST-1].wcls == W8
        |-> o_out_sample[31:8] == 24'd0)
        else $error("8-bit result has bits above its width");

endmodule

/* verif/tb.sv */
// Testbench for audio_sample_format_converter: random beats over every format pair, scoreboarded.
`timescale 1ns / 1ps

module tb;
    import asfc_pkg::*;

    localparam int LIMIT = 400000;

    class conv_scoreboard;
        logic [2:0] src_fmt;
        logic [2:0] dst_fmt;
        logic [31:0] pending[$];
        int errors;

        function new();
            src_fmt = FMT_U8;
            dst_fmt = FMT_U8;
            errors = 0;
        endfunction

        // single bit pattern to double, exact
        function real sgl_to_real(logic [31:0] b);
            real v;
            if (b[30:23] == 8'hFF) begin
                if (b[22:0] != 0) return $bitstoreal(64'h7FF8_0000_0000_0000);
                return $bitstoreal({b[31], 11'h7FF, 52'h0});
            end
            if (b[30:23] == 8'h00) begin
                v = real'(b[22:0]) / (2.0 ** 149);
                return b[31] ? -v : v;
            end
            return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'h0});
        endfunction

        // double to single, round to nearest even
        function logic [31:0] real_to_sgl(real r);
            logic [63:0] d;
            logic s;
            int e;
            int sh;
            logic [63:0] m;
            logic [63:0] q;
            logic [63:0] rem;
            logic [63:0] half;
            d = $realtobits(r);
            s = d[63];
            if (d[62:52] == 11'h7FF) begin
                if (d[51:0] != 0) return 32'h7FC0_0000;
                return {s, 8'hFF, 23'h0};
            end
            if (d[62:52] == 11'h0) return {s, 31'h0};
            e = int'(d[62:52]) - 1023;
            m = {11'h0, 1'b1, d[51:0]};
            sh = (e >= -126) ? 29 : 29 + (-126 - e);
            if (sh > 60) return {s, 31'h0};
            q = m >> sh;
            rem = m & ((64'h1 << sh) - 1);
            half = 64'h1 << (sh - 1);
            if (rem > half || (rem == half && q[0])) q = q + 1;
            if (e < -126) return {s, q[30:0]};
            if (q[24]) begin
                q = q >> 1;
                e = e + 1;
            end
            if (e > 127) return {s, 8'hFF, 23'h0};
            return {s, 8'(e + 127), q[22:0]};
        endfunction

        function longint trunc_pos(real v);
            longint q;
            q = longint'(v);
            if (real'(q) > v) q = q - 1;
            return q;
        endfunction

        function int width_of(logic [2:0] f);
            return (f < FMT_U16) ? 8 : (f < FMT_U32) ? 16 : 32;
        endfunction

        function logic [31:0] uint_to_float(logic [31:0] u, int w);
            real fac;
            real p;
            real maxu;
            if (w <= 16) begin
                maxu = real'((64'h1 << w) - 1);
                fac = sgl_to_real(real_to_sgl(1.0 / (0.5 * maxu)));
                p = sgl_to_real(real_to_sgl(real'(u) * fac));
                return real_to_sgl(p - 1.0);
            end
            fac = 1.0 / (0.5 * 4294967295.0);
            p = real'(u) * fac;
            return real_to_sgl(p - 1.0);
        endfunction

        function logic [31:0] float_to_uint(logic [31:0] x, int w);
            logic [31:0] maxu;
            real fac;
            real v;
            maxu = 32'((64'h1 << w) - 1);
            if (x[30:23] == 8'hFF && x[22:0] != 0) return 32'h0;
            if (w <= 16) begin
                fac = sgl_to_real(real_to_sgl(0.5 * real'(maxu)));
                v = sgl_to_real(real_to_sgl(sgl_to_real(x) + 1.0));
                v = sgl_to_real(real_to_sgl(v * fac));
                if (!(v > 0.0)) return 32'h0;
                if (v >= real'(maxu) + 1.0) return maxu;
                return 32'(trunc_pos(v));
            end
            v = (sgl_to_real(x) + 1.0) * (0.5 * 4294967295.0);
            if (!(v > 0.0)) return 32'h0;
            if (v >= 4294967296.0) return maxu;
            return 32'(trunc_pos(v));
        endfunction

        function logic [31:0] convert(logic [31:0] x);
            int ws;
            int wd;
            logic [63:0] v;
            logic [31:0] r;
            if (src_fmt > FMT_F32 || dst_fmt > FMT_F32) return 32'h0;
            if (src_fmt == FMT_F32 && dst_fmt == FMT_F32) return x;
            if (src_fmt == FMT_F32) begin
                wd = width_of(dst_fmt);
                r = float_to_uint(x, wd);
                if (dst_fmt[0]) r = r ^ 32'(64'h1 << (wd - 1));
                return r & 32'((64'h1 << wd) - 1);
            end
            ws = width_of(src_fmt);
            v = {32'h0, x} & ((64'h1 << ws) - 1);
            if (dst_fmt == FMT_F32) begin
                if (src_fmt[0]) v = v ^ (64'h1 << (ws - 1));
                return uint_to_float(v[31:0], ws);
            end
            wd = width_of(dst_fmt);
            if (src_fmt[0] != dst_fmt[0]) v = v ^ (64'h1 << (ws - 1));
            if (ws > wd) v = v >> (ws - wd);
            else v = v << (wd - ws);
            return 32'(v & ((64'h1 << wd) - 1));
        endfunction

        function void note_input(logic [31:0] x);
            pending.push_back(convert(x));
        endfunction

        function void check_result(logic [31:0] y);
            logic [31:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected out_sample %h", $time, y);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want !== y) begin
                $display("%0t: out_sample expected %h actual %h", $time, want, y);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_in_sample;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_out_sample;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [2:0]  i_cfg_data;

    conv_scoreboard sb;
    int cycles;
    int max_gap;
    int hold_cycles;
    logic [31:0] float_corners[$];
    logic [31:0] int_corners[$];

    audio_sample_format_converter uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_sample = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_SRC;
        i_cfg_data = '0;
        cycles = 0;
        max_gap = 7;
        hold_cycles = 0;
        sb = new();
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("audio_sample_format_converter regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_sample);
    end

    // output side: random stalls, one long hold-off on request
    initial begin
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            gap = $urandom_range(max_gap, 0);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_sample(logic [31:0] x);
        int gap;
        gap = $urandom_range(max_gap, 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_sample <= x;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(x);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_formats(logic [2:0] src, logic [2:0] dst);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_SRC;
        i_cfg_data <= src;
        @(posedge i_clk);
        i_cfg_index <= CFG_DST;
        i_cfg_data <= dst;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.src_fmt = src;
        sb.dst_fmt = dst;
    endtask

    function automatic logic [31:0] rand_sample(logic [2:0] src);
        int pick;
        pick = $urandom_range(9, 0);
        if (pick == 0) return float_corners[$urandom_range(float_corners.size() - 1, 0)];
        if (pick == 1) return int_corners[$urandom_range(int_corners.size() - 1, 0)];
        if (src == FMT_F32 && pick < 7) begin
            return {1'($urandom), 8'($urandom_range(127, 100)), 23'($urandom)};
        end
        return $urandom;
    endfunction

    initial begin
        int p;
        int n;
        float_corners = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                          32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFA0_0001,
                          32'h3F00_0000, 32'h4000_0000, 32'h0000_0001, 32'h3F7F_FFFF,
                          32'hBF7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF};
        int_corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0080, 32'h0000_007F,
                        32'h0000_8000, 32'h0000_7FFF, 32'h8000_0000, 32'h7FFF_FFFF};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_formats(FMT_F32, FMT_S16);
        foreach (float_corners[i]) send_sample(float_corners[i]);
        set_formats(FMT_S32, FMT_U8);
        foreach (int_corners[i]) send_sample(int_corners[i]);

        for (p = 0; p < 64; p++) begin
            set_formats(3'(p / 8), 3'(p % 8));
            max_gap = ($urandom_range(3, 0) == 0) ? 0 : 7;
            if (p == 20) begin
                max_gap = 0;
                hold_cycles = 300;
            end
            for (n = 0; n < 27; n++) send_sample(rand_sample(3'(p / 8)));
        end

        drain();
        if (sb.errors == 0) begin
            $display("audio_sample_format_converter regression: pass");
        end else begin
            $display("audio_sample_format_converter regression: fail");
        end
        $finish;
    end
endmodule
